FILE: design/kmtt_pkg.sv
// ----------------------------------------------------------------------------
// kmtt_pkg
// Shared types and constants of the keyed millisecond timer table.
// ----------------------------------------------------------------------------
package kmtt_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ID_W  = 16;
	localparam int MS_W  = 32;
	localparam int DL_W  = MS_W + 1;
	localparam int ENT_W = ID_W + DL_W;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_FIRE    = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: design/keyed_millisecond_timer_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_millisecond_timer_table_unit
// Table of timers keyed by id against a saturating millisecond run clock.
// ----------------------------------------------------------------------------
//  channel | signals                                   | items
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_stall, req_type, timer_id,   | set/cancel or tick
//          | is_absolute, time_ms                      |
//  out     | out_valid, out_stall, result_kind,        | ack, fires, summary
//          | fired_id, ms_to_next, table_full, last    |
//
// Timers sit in one RAM in insertion order, dense from position 0.
// Every item makes one compacting pass over the live entries, one read a cycle
// while no stalled fire result holds it, as set by the single RAM read port.
// A stalled fire result holds the pass; the final result waits in the output
// register while the next item is already taken.
// Reset clears the clock, the entry count and all handshake state; no RAM clearing.
module keyed_millisecond_timer_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [kmtt_pkg::ID_W-1:0]  timer_id,
	input  logic                       is_absolute,
	input  logic signed [kmtt_pkg::MS_W-1:0] time_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 result_kind,
	output logic [kmtt_pkg::ID_W-1:0]  fired_id,
	output logic [kmtt_pkg::MS_W-1:0]  ms_to_next,
	output logic                       table_full,
	output logic                       last
);

	kmtt_pkg::state_t st_q, st_d;

	// control state
	logic [kmtt_pkg::MS_W-1:0]  clk_ms_q;
	logic [kmtt_pkg::CNT_W-1:0] cnt_q;
	logic [kmtt_pkg::CNT_W-1:0] rd_idx_q;
	logic [kmtt_pkg::CNT_W-1:0] w_q;
	logic [kmtt_pkg::IDX_W-1:0] ev_idx_q;
	logic                       pend_q;
	logic                       out_valid_q;

	// captured request and scan payload
	logic                       tick_q;
	logic [kmtt_pkg::ID_W-1:0]  id_q;
	logic                       abs_q;
	logic [kmtt_pkg::MS_W-1:0]  time_q;
	logic [kmtt_pkg::DL_W-1:0]  best_q;

	// output register
	kmtt_pkg::kind_t            kind_q;
	logic [kmtt_pkg::ID_W-1:0]  fid_q;
	logic [kmtt_pkg::MS_W-1:0]  ms_q;
	logic                       full_q;
	logic                       last_q;

	// RAM
	logic                        mem_we;
	logic [kmtt_pkg::IDX_W-1:0]  mem_waddr;
	logic [kmtt_pkg::ENT_W-1:0]  mem_wdata;
	logic [kmtt_pkg::IDX_W-1:0]  mem_raddr;
	logic [kmtt_pkg::ENT_W-1:0]  mem_rdata;

	logic [kmtt_pkg::ID_W-1:0]  ev_id;
	logic [kmtt_pkg::DL_W-1:0]  ev_dl;
	logic [kmtt_pkg::DL_W-1:0]  left;
	logic [kmtt_pkg::DL_W-1:0]  new_dl;
	logic                       in_acc;
	logic                       out_free;
	logic                       matched, expired, hold, proc, keep, issue, add;
	logic                       no_add;

	logic                       out_load;
	kmtt_pkg::kind_t            o_kind;
	logic [kmtt_pkg::ID_W-1:0]  o_id;
	logic [kmtt_pkg::MS_W-1:0]  o_ms;
	logic                       o_full;
	logic                       o_last;

	kmtt_ram #(
		.WIDTH(kmtt_pkg::ENT_W),
		.DEPTH(kmtt_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_stall = (st_q != kmtt_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign ev_id  = mem_rdata[kmtt_pkg::ENT_W-1:kmtt_pkg::DL_W];
	assign ev_dl  = mem_rdata[kmtt_pkg::DL_W-1:0];
	assign left   = ev_dl - {1'b0, clk_ms_q};
	assign new_dl = abs_q ? {1'b0, time_q} : ({1'b0, clk_ms_q} + {1'b0, time_q});
	// negative cancels; an absolute time already passed is dropped
	assign no_add = time_q[kmtt_pkg::MS_W-1] || (abs_q && (time_q < clk_ms_q));

	always_comb begin
		st_d      = st_q;
		matched   = 1'b0;
		expired   = 1'b0;
		hold      = 1'b0;
		proc      = 1'b0;
		keep      = 1'b0;
		issue     = 1'b0;
		add       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = w_q[kmtt_pkg::IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = rd_idx_q[kmtt_pkg::IDX_W-1:0];
		out_load  = 1'b0;
		o_kind    = kmtt_pkg::KIND_ACK;
		o_id      = '0;
		o_ms      = '0;
		o_full    = 1'b0;
		o_last    = 1'b0;
		unique case (st_q)
			kmtt_pkg::ST_IDLE: begin
				if (in_acc) begin
					st_d = kmtt_pkg::ST_SCAN;
				end
			end
			kmtt_pkg::ST_SCAN: begin
				matched = pend_q && !tick_q && (ev_id == id_q);
				expired = pend_q && tick_q && (ev_dl <= {1'b0, clk_ms_q});
				hold    = expired && !out_free;
				proc    = pend_q && !hold;
				keep    = proc && !expired && !matched;
				// re-read the same entry so the data stays put while stalled
				if (hold) begin
					mem_raddr = ev_idx_q;
				end
				issue = !hold && (rd_idx_q < cnt_q);
				if (proc && expired) begin
					out_load = 1'b1;
					o_kind   = kmtt_pkg::KIND_FIRE;
					o_id     = ev_id;
				end
				// compaction: writes trail the reads, so no forwarding needed
				mem_we = keep;
				if (!pend_q && (rd_idx_q >= cnt_q)) begin
					st_d = kmtt_pkg::ST_DONE;
				end
			end
			kmtt_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					o_last   = 1'b1;
					st_d     = kmtt_pkg::ST_IDLE;
					if (tick_q) begin
						o_kind = kmtt_pkg::KIND_SUMMARY;
						o_ms   = best_q[kmtt_pkg::DL_W-1] ? '1 : best_q[kmtt_pkg::MS_W-1:0];
					end else if (!no_add) begin
						if (w_q == kmtt_pkg::CNT_W'(kmtt_pkg::SLOTS)) begin
							o_full = 1'b1;
						end else begin
							add       = 1'b1;
							mem_we    = 1'b1;
							mem_wdata = {id_q, new_dl};
						end
					end
				end
			end
			default: begin
				st_d = kmtt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= kmtt_pkg::ST_IDLE;
			clk_ms_q    <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			w_q         <= '0;
			ev_idx_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_acc) begin
				rd_idx_q <= '0;
				w_q      <= '0;
				pend_q   <= 1'b0;
				if (req_type && (clk_ms_q != '1)) begin
					clk_ms_q <= clk_ms_q + kmtt_pkg::MS_W'(1);
				end
			end
			if (st_q == kmtt_pkg::ST_SCAN) begin
				if (keep) begin
					w_q <= w_q + kmtt_pkg::CNT_W'(1);
				end
				if (!hold) begin
					if (issue) begin
						pend_q   <= 1'b1;
						ev_idx_q <= rd_idx_q[kmtt_pkg::IDX_W-1:0];
						rd_idx_q <= rd_idx_q + kmtt_pkg::CNT_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
				end
			end
			if ((st_q == kmtt_pkg::ST_DONE) && out_free) begin
				cnt_q <= add ? (w_q + kmtt_pkg::CNT_W'(1)) : w_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tick_q <= req_type;
			id_q   <= timer_id;
			abs_q  <= is_absolute;
			time_q <= $unsigned(time_ms);
			best_q <= '0;
		end
		if (keep && tick_q) begin
			if ((best_q == '0) || (left < best_q)) begin
				best_q <= left;
			end
		end
		if (out_load) begin
			kind_q <= o_kind;
			fid_q  <= o_id;
			ms_q   <= o_ms;
			full_q <= o_full;
			last_q <= o_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign fired_id    = fid_q;
	assign ms_to_next  = ms_q;
	assign table_full  = full_q;
	assign last        = last_q;

endmodule

FILE: design/kmtt_ram.sv
// ----------------------------------------------------------------------------
// kmtt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/kmtt_chk.sv
// ----------------------------------------------------------------------------
// kmtt_chk
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module kmtt_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       req_type,
	input logic [kmtt_pkg::ID_W-1:0]  timer_id,
	input logic                       is_absolute,
	input logic signed [kmtt_pkg::MS_W-1:0] time_ms,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 result_kind,
	input logic [kmtt_pkg::ID_W-1:0]  fired_id,
	input logic [kmtt_pkg::MS_W-1:0]  ms_to_next,
	input logic                       table_full,
	input logic                       last
);

	// an accepted item keeps the input closed for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_kind)
			&& $stable(fired_id) && $stable(ms_to_next) && $stable(last)))
		else $error("stalled result changed");

	// fires never close an item, acks and summaries always do
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_kind == kmtt_pkg::KIND_FIRE && !last)
			|| (result_kind == kmtt_pkg::KIND_ACK && last)
			|| (result_kind == kmtt_pkg::KIND_SUMMARY && last)))
		else $error("bad kind/last pairing");

	// while idle only the closing result of the previous item can be pending
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && out_valid) |-> last)
		else $error("open result while idle");

endmodule

bind keyed_millisecond_timer_table_unit kmtt_chk u_kmtt_chk (.*);

FILE: dv/kmtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmtt_checker
// Watches both channels of the timer table, keeps its own copy of the run
// clock and the pending timers, and compares every result with the oldest
// expected one.
// ----------------------------------------------------------------------------
module kmtt_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      req_type,
	input  logic [kmtt_pkg::ID_W-1:0] timer_id,
	input  logic                      is_absolute,
	input  logic [kmtt_pkg::MS_W-1:0] time_ms,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [1:0]                result_kind,
	input  logic [kmtt_pkg::ID_W-1:0] fired_id,
	input  logic [kmtt_pkg::MS_W-1:0] ms_to_next,
	input  logic                      table_full,
	input  logic                      last,
	output int                        fail_count,
	output int                        pending,
	output int                        items_seen,
	output int                        results_seen,
	output int                        fires_seen,
	output int                        full_seen
);
	import kmtt_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic [MS_W-1:0]   ms;
		logic              full;
		logic              last;
	} result_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] deadline;
	} live_timer_t;

	localparam logic [DL_W-1:0] MS_SAT = {1'b0, {MS_W{1'b1}}};

	result_t         expected_q[$];
	live_timer_t     live_timers[$];   // insertion order, oldest first
	logic [MS_W-1:0] clock_ms;
	int              n_fail, n_items, n_results, n_fires, n_full;
	result_t         seen, want;

	function automatic result_t make_result(kind_t k, logic [ID_W-1:0] id,
			logic [MS_W-1:0] ms, logic full, logic fin);
		result_t r;
		r.kind = k;
		r.id   = id;
		r.ms   = ms;
		r.full = full;
		r.last = fin;
		return r;
	endfunction

	task automatic predict_request(input logic tick, input logic [ID_W-1:0] id,
			input logic absolute, input logic [MS_W-1:0] t);
		live_timer_t     kept[$];
		live_timer_t     fresh;
		logic [DL_W-1:0] best, left;
		if (tick) begin
			if (clock_ms != {MS_W{1'b1}})
				clock_ms++;
			best = '0;
			foreach (live_timers[i]) begin
				if (live_timers[i].deadline <= {1'b0, clock_ms}) begin
					expected_q.push_back(make_result(KIND_FIRE, live_timers[i].id,
						'0, 1'b0, 1'b0));
				end else begin
					left = live_timers[i].deadline - {1'b0, clock_ms};
					if (best == '0 || left < best)
						best = left;
					kept.push_back(live_timers[i]);
				end
			end
			live_timers = kept;
			if (best > MS_SAT)
				best = MS_SAT;
			expected_q.push_back(make_result(KIND_SUMMARY, '0, best[MS_W-1:0], 1'b0, 1'b1));
		end else begin
			// an existing timer with this id goes first, whatever follows
			for (int i = 0; i < live_timers.size(); i++) begin
				if (live_timers[i].id == id) begin
					live_timers.delete(i);
					break;
				end
			end
			if (t[MS_W-1] || (absolute && t < clock_ms)) begin
				expected_q.push_back(make_result(KIND_ACK, '0, '0, 1'b0, 1'b1));
			end else if (live_timers.size() >= SLOTS) begin
				expected_q.push_back(make_result(KIND_ACK, '0, '0, 1'b1, 1'b1));
			end else begin
				fresh.id       = id;
				fresh.deadline = absolute ? {1'b0, t} : {1'b0, clock_ms} + {1'b0, t};
				live_timers.push_back(fresh);
				expected_q.push_back(make_result(KIND_ACK, '0, '0, 1'b0, 1'b1));
			end
		end
	endtask

	task automatic note_mismatch(input string what, input result_t exp_r, input result_t got_r);
		n_fail++;
		if (n_fail <= 10)
			$display("[%0t] %s: expected kind=%0d id=%h ms=%0d full=%b last=%b, got kind=%0d id=%h ms=%0d full=%b last=%b",
				$realtime, what, exp_r.kind, exp_r.id, exp_r.ms, exp_r.full, exp_r.last,
				got_r.kind, got_r.id, got_r.ms, got_r.full, got_r.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			live_timers.delete();
			clock_ms  = '0;
			n_fail    = 0;
			n_items   = 0;
			n_results = 0;
			n_fires   = 0;
			n_full    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = make_result(kind_t'(result_kind), fired_id, ms_to_next, table_full, last);
				n_results++;
				if (seen.kind == KIND_FIRE)
					n_fires++;
				if (seen.kind == KIND_ACK && seen.full)
					n_full++;
				if (expected_q.size() == 0) begin
					note_mismatch("unexpected result", '0, seen);
				end else begin
					want = expected_q.pop_front();
					if (seen.kind !== want.kind || seen.id !== want.id || seen.ms !== want.ms
							|| seen.full !== want.full || seen.last !== want.last)
						note_mismatch("result mismatch", want, seen);
				end
			end
			if (in_valid && !in_stall) begin
				n_items++;
				predict_request(req_type, timer_id, is_absolute, time_ms);
			end
		end
		fail_count   <= n_fail;
		pending      <= expected_q.size();
		items_seen   <= n_items;
		results_seen <= n_results;
		fires_seen   <= n_fires;
		full_seen    <= n_full;
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives set, cancel and tick items into the timer table with random gaps and
// output stalls; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import kmtt_pkg::*;

	localparam int N_RANDOM    = 380;
	localparam int HOLD_CYCLES = 300;
	// ~400 items, up to 17 results each, each result possibly stalled, plus holds
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  req_type    = 1'b0;
	logic [ID_W-1:0]       timer_id    = '0;
	logic                  is_absolute = 1'b0;
	logic signed [MS_W-1:0] time_ms    = '0;
	logic                  out_stall   = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic [1:0]            result_kind;
	logic [ID_W-1:0]       fired_id;
	logic [MS_W-1:0]       ms_to_next;
	logic                  table_full;
	logic                  last;

	int fail_count, pending, items_seen, results_seen, fires_seen, full_seen;
	int idle_pct    = 20;
	int stall_pct   = 20;
	int hold_asks   = 0;
	int hold_served = 0;
	int ticks_sent  = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	keyed_millisecond_timer_table_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.timer_id    (timer_id),
		.is_absolute (is_absolute),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.fired_id    (fired_id),
		.ms_to_next  (ms_to_next),
		.table_full  (table_full),
		.last        (last)
	);

	kmtt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.timer_id     (timer_id),
		.is_absolute  (is_absolute),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.fired_id     (fired_id),
		.ms_to_next   (ms_to_next),
		.table_full   (table_full),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.fires_seen   (fires_seen),
		.full_seen    (full_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycle_count, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus the long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_asks) begin
				hold_served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_req(input logic tick, input logic [ID_W-1:0] id,
			input logic absolute, input logic [MS_W-1:0] t);
		in_valid    <= 1'b1;
		req_type    <= tick;
		timer_id    <= id;
		is_absolute <= absolute;
		time_ms     <= t;
		do @(posedge clk); while (in_stall);
		if (tick)
			ticks_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_random_req();
		logic [ID_W-1:0] id;
		logic            absolute;
		logic [MS_W-1:0] t;
		int              roll;
		roll = $urandom_range(0, 99);
		if (roll < 38) begin
			// other fields are don't-care on a tick, so randomize them too
			send_req(1'b1, ID_W'($urandom), 1'($urandom), $urandom);
		end else begin
			id       = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 19));
			absolute = 1'($urandom);
			roll     = $urandom_range(0, 99);
			if (roll < 72)
				t = absolute ? MS_W'(ticks_sent + int'($urandom_range(0, 14)) - 3)
				             : MS_W'($urandom_range(0, 14));
			else if (roll < 82)
				t = {1'b1, 31'($urandom)};
			else if (roll < 92)
				t = $urandom;
			else begin
				case ($urandom_range(0, 3))
					0: t = 32'h7FFF_FFFF;
					1: t = 32'h8000_0000;
					2: t = 32'h0000_0000;
					default: t = 32'hFFFF_FFFF;
				endcase
			end
			send_req(1'b0, id, absolute, t);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, past and present absolute times, cancels, replacement
		send_req(1'b1, 16'h0000, 1'b0, 32'h0000_0000);
		send_req(1'b0, 16'hFFFF, 1'b1, 32'h0000_0000);
		send_req(1'b0, 16'h0000, 1'b0, 32'h0000_0000);
		send_req(1'b0, 16'h0001, 1'b1, 32'h0000_0001);
		send_req(1'b0, 16'h0002, 1'b0, 32'hFFFF_FFFF);
		send_req(1'b0, 16'h0003, 1'b0, 32'h7FFF_FFFF);
		send_req(1'b0, 16'h0003, 1'b1, 32'h8000_0000);
		send_req(1'b0, 16'h8000, 1'b1, 32'h7FFF_FFFF);
		send_req(1'b0, 16'h8000, 1'b0, 32'h0000_0001);
		// fill the table, overflow it, then fire every entry on one tick
		for (int i = 0; i < SLOTS - 3; i++)
			send_req(1'b0, ID_W'(16'h0010 + i), 1'b0, 32'h0000_0001);
		send_req(1'b0, 16'h5555, 1'b0, 32'h0000_0005);
		send_req(1'b1, 16'hAAAA, 1'b1, 32'h5555_5555);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 100)
				hold_asks++;
			if (n == 200) begin
				// drop valid so the last item is not taken again, then drain
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n == 250) begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			if (n == 330) begin
				idle_pct  = 20;
				stall_pct = 20;
			end
			send_random_req();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d items (%0d ticks) and %0d results:", items_seen, ticks_sent,
			results_seen);
		$display("%0d timers fired, %0d sets dropped on a full table", fires_seen, full_seen);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: keyed_millisecond_timer_table_unit.f
design/kmtt_pkg.sv
design/kmtt_ram.sv
design/keyed_millisecond_timer_table_unit.sv
design/kmtt_chk.sv
dv/kmtt_checker.sv
dv/tb_top.sv
